### hw/rtl/bernstein_polynomial_evaluator_macros.svh
// ----------------------------------------------------------------------------
// bernstein polynomial evaluator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BERNSTEIN_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define BERNSTEIN_POLYNOMIAL_EVALUATOR_MACROS_SVH

// same-cycle implication
`define BPE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// widths, constants and types shared by the bernstein evaluator modules
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int MAX_DEGREE      = 8;
    localparam int VALUE_BITS      = 32;
    localparam int THETA_FRAC_BITS = 16;
    localparam int THETA_BITS      = THETA_FRAC_BITS + 1;
    localparam int DEG_BITS        = 4;
    localparam int N_CTRL          = MAX_DEGREE + 1;

    // full product of a (VALUE_BITS+1) difference and a (THETA_BITS+1) signed theta
    localparam int PROD_BITS = VALUE_BITS + THETA_FRAC_BITS + 3;
    // product scaled back by the theta fraction
    localparam int SUM_BITS  = PROD_BITS - THETA_FRAC_BITS;

    localparam logic [DEG_BITS-1:0] DEGREE_RESET = DEG_BITS'(3);
    localparam logic [DEG_BITS-1:0] DEGREE_MAX   = DEG_BITS'(MAX_DEGREE);

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic        [THETA_BITS-1:0] t_theta;

    // per-beat control that travels down the cell row
    typedef struct packed {
        logic                valid;
        logic                err;
        logic [DEG_BITS-1:0] degree;
    } t_ctl;

endpackage

### hw/rtl/bpe_cell.sv
// ----------------------------------------------------------------------------
// bpe_cell
// one de casteljau level: lane multiplies in the first stage,
// rounded add with saturation in the second
// ----------------------------------------------------------------------------
`include "bernstein_polynomial_evaluator_macros.svh"

module bpe_cell
    import bpe_pkg::*;
#(
    parameter int LEVEL = 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_theta i_theta,
    input  t_value i_b [N_CTRL],
    output t_ctl   o_ctl,
    output t_theta o_theta,
    output t_value o_b [N_CTRL]
);

    localparam logic [PROD_BITS-1:0] HALF =
        {{(PROD_BITS - THETA_FRAC_BITS){1'b0}}, 1'b1, {(THETA_FRAC_BITS - 1){1'b0}}};
    localparam logic [SUM_BITS-1:0] SUM_HI =
        {{(SUM_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_LO =
        {{(SUM_BITS - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

    // stage a: difference times theta
    logic signed [VALUE_BITS:0]    w_diff [MAX_DEGREE];
    logic signed [PROD_BITS-1:0]   n_prod [MAX_DEGREE];
    logic signed [PROD_BITS-1:0]   r_prod [MAX_DEGREE];
    t_ctl                          r_a_ctl;
    t_theta                        r_a_theta;
    t_value                        r_a_b [N_CTRL];

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            w_diff[i] = $signed({i_b[i+1][VALUE_BITS-1], i_b[i+1]})
                      - $signed({i_b[i][VALUE_BITS-1], i_b[i]});
            if (i < LEVEL) begin
                n_prod[i] = w_diff[i] * $signed({1'b0, i_theta});
            end else begin
                n_prod[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_theta <= i_theta;
        r_a_b     <= i_b;
        r_prod    <= n_prod;
    end

    // stage b: round to nearest, add, saturate
    logic signed [PROD_BITS-1:0] w_round [MAX_DEGREE];
    logic signed [SUM_BITS-1:0]  w_shift [MAX_DEGREE];
    logic signed [SUM_BITS-1:0]  w_sum   [MAX_DEGREE];
    logic                        w_active;
    t_value                      n_b [N_CTRL];
    t_ctl                        r_b_ctl;
    t_theta                      r_b_theta;
    t_value                      r_b_b [N_CTRL];

    assign w_active = (r_a_ctl.degree >= DEG_BITS'(LEVEL));

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            w_round[i] = r_prod[i] + $signed(HALF);
            w_shift[i] = SUM_BITS'(w_round[i] >>> THETA_FRAC_BITS);
            w_sum[i]   = $signed({{(SUM_BITS - VALUE_BITS){r_a_b[i][VALUE_BITS-1]}}, r_a_b[i]})
                       + w_shift[i];
            if ((i < LEVEL) && w_active) begin
                if (w_sum[i] > $signed(SUM_HI)) begin
                    n_b[i] = $signed(SUM_HI[VALUE_BITS-1:0]);
                end else if (w_sum[i] < $signed(SUM_LO)) begin
                    n_b[i] = $signed(SUM_LO[VALUE_BITS-1:0]);
                end else begin
                    n_b[i] = w_sum[i][VALUE_BITS-1:0];
                end
            end else begin
                n_b[i] = r_a_b[i];
            end
        end
        n_b[MAX_DEGREE] = r_a_b[MAX_DEGREE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_theta <= r_a_theta;
        r_b_b     <= n_b;
    end

    assign o_ctl   = r_b_ctl;
    assign o_theta = r_b_theta;
    assign o_b     = r_b_b;

    `BPE_ASSERT_IMPL(a_idle_pass, r_b_ctl.valid && (r_b_ctl.degree < DEG_BITS'(LEVEL)), r_b_b[0] == $past(r_a_b[0]), "inactive level changed lane 0")
    `BPE_ASSERT_IMPL(a_ctl_carry, r_b_ctl.valid, r_b_ctl == $past(i_ctl, 2), "beat control lost in cell")
    `BPE_ASSERT_IMPL(a_top_untouched, r_b_ctl.valid, r_b_b[MAX_DEGREE] == $past(i_b[MAX_DEGREE], 2), "last control modified")

endmodule

### hw/rtl/bernstein_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// bernstein_polynomial_evaluator
// pipelined de casteljau evaluation of a bernstein polynomial in q16.16
//
//   channel   direction  beat marker          payload
//   command   in         start && !busy       i_theta, i_control_0 .. i_control_8
//   result    out        o_strobe             o_value, o_theta_error
//   config    in         i_cfg_we             i_cfg_data (degree)
//
// - one beat accepted per clock while busy is low; each beat passes through
//   the input register, two stages per level and the output reg before the
//   strobe rises with its result
// - latency is fixed by the row of MAX_DEGREE level cells; lower degrees pass
//   through the upper cells unchanged
// - busy is high only during reset and the cycle after it
// - the result is shown for one cycle; the receiver cannot stall
// - degree resets to 3; write it only with the pipeline empty
// ----------------------------------------------------------------------------
`include "bernstein_polynomial_evaluator_macros.svh"

module bernstein_polynomial_evaluator
    import bpe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command
    input  logic                      start,
    output logic                      busy,
    input  logic [THETA_BITS-1:0]     i_theta,
    input  logic signed [VALUE_BITS-1:0] i_control_0,
    input  logic signed [VALUE_BITS-1:0] i_control_1,
    input  logic signed [VALUE_BITS-1:0] i_control_2,
    input  logic signed [VALUE_BITS-1:0] i_control_3,
    input  logic signed [VALUE_BITS-1:0] i_control_4,
    input  logic signed [VALUE_BITS-1:0] i_control_5,
    input  logic signed [VALUE_BITS-1:0] i_control_6,
    input  logic signed [VALUE_BITS-1:0] i_control_7,
    input  logic signed [VALUE_BITS-1:0] i_control_8,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [DEG_BITS-1:0]       i_cfg_data,
    // result
    output logic                      o_strobe,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                      o_theta_error
);

    // accepting edge to result edge, in cycles
    localparam int LAT = 2 * MAX_DEGREE + 2;

    // degree register
    logic [DEG_BITS-1:0] r_degree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
        end else if (i_cfg_we) begin
            r_degree <= i_cfg_data;
        end
    end

    // busy covers reset so no beat is taken while the row is cleared
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // input register
    logic   w_accept;
    logic   w_err;
    t_value w_ctrl [N_CTRL];
    t_ctl   n_in_ctl;
    t_ctl   r_in_ctl;
    t_theta r_in_theta;
    t_value r_in_b [N_CTRL];

    assign w_accept = start && !r_busy;
    // above 1.0: integer bit set and any fraction bit set
    assign w_err    = i_theta[THETA_FRAC_BITS] && (|i_theta[THETA_FRAC_BITS-1:0]);

    assign w_ctrl[0] = i_control_0;
    assign w_ctrl[1] = i_control_1;
    assign w_ctrl[2] = i_control_2;
    assign w_ctrl[3] = i_control_3;
    assign w_ctrl[4] = i_control_4;
    assign w_ctrl[5] = i_control_5;
    assign w_ctrl[6] = i_control_6;
    assign w_ctrl[7] = i_control_7;
    assign w_ctrl[8] = i_control_8;

    always_comb begin
        n_in_ctl.valid  = w_accept;
        n_in_ctl.err    = w_err;
        // degrees above the cell count run as the full row
        n_in_ctl.degree = (r_degree > DEGREE_MAX) ? DEGREE_MAX : r_degree;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_theta <= i_theta;
        r_in_b     <= w_ctrl;
    end

    // row of level cells, highest level first
    t_ctl   w_ctl   [MAX_DEGREE+1];
    t_theta w_theta [MAX_DEGREE+1];
    t_value w_b     [MAX_DEGREE+1][N_CTRL];

    assign w_ctl[0]   = r_in_ctl;
    assign w_theta[0] = r_in_theta;
    assign w_b[0]     = r_in_b;

    for (genvar s = 0; s < MAX_DEGREE; s++) begin : g_cell
        bpe_cell #(
            .LEVEL   (MAX_DEGREE - s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[s]),
            .i_theta (w_theta[s]),
            .i_b     (w_b[s]),
            .o_ctl   (w_ctl[s+1]),
            .o_theta (w_theta[s+1]),
            .o_b     (w_b[s+1])
        );
    end

    // output register; theta is only needed inside the cells
    logic   r_strobe;
    logic   r_err;
    t_value r_value;
    t_value n_value;

    assign n_value = w_ctl[MAX_DEGREE].err ? '0 : w_b[MAX_DEGREE][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_ctl[MAX_DEGREE].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err   <= w_ctl[MAX_DEGREE].err;
        r_value <= n_value;
    end

    assign o_strobe      = r_strobe;
    assign o_value       = r_value;
    assign o_theta_error = r_err;

    `BPE_ASSERT_IMPL(a_strobe_latency, o_strobe, $past(start && !busy, LAT), "result beat without a command beat")
    `BPE_ASSERT_IMPL(a_err_zero, o_strobe && o_theta_error, o_value == '0, "error beat with nonzero value")
    `BPE_ASSERT_IMPL(a_theta_zero, o_strobe && $past(start && !busy && (i_theta == '0), LAT), o_value == $past(i_control_0, LAT), "theta zero must return control 0")
    `BPE_ASSERT_NEXT(a_busy_release, 1'b1, !busy, "busy outside reset")

endmodule
